FILE: hdl/assert_macros.svh
// assertion macros shared by the rtl files
// no dependencies; checks compile away when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(name, clk, rst_n, cond, msg)
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: hdl/baro_pkg.sv
// constants, types and elaboration-time tables for the barometric altitude unit
// no dependencies
package baro_pkg;

    localparam int P_W    = 17;
    localparam int ALT_W  = 24;
    localparam int SUM_W  = 24;
    localparam int MUL_W  = 32;
    localparam int PROD_W = 64;
    localparam int ITER   = 24;
    localparam int LOG_W  = 29;
    localparam int LDIF_W = 30;

    localparam logic [P_W-1:0]          REF_RESET = 17'd101325;
    localparam logic [21:0]             EXPO_Q24  = 22'd3192620;
    localparam logic [22:0]             ALT_SCALE = 23'd4433000;
    localparam logic signed [ALT_W-1:0] ALT_MIN   = -24'sd1000000;
    localparam logic signed [ALT_W-1:0] ALT_MAX   = 24'sd4433000;
    localparam logic [30:0]             ONE_Q30   = 31'h4000_0000;

    typedef logic [ITER-1:0][30:0] exp_tab_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] bt;
        v  = v_in;
        r  = '0;
        bt = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (v >= r + bt) begin
                v = v - (r + bt);
                r = (r >> 1) + bt;
            end else begin
                r = r >> 1;
            end
            bt = bt >> 2;
        end
        return r;
    endfunction

    // 2^(2^-(i+1)) in q30, chained truncating square roots starting from 2.0
    function automatic exp_tab_t exp_table();
        exp_tab_t    t;
        logic [63:0] c;
        c = 64'h8000_0000;
        for (int i = 0; i < ITER; i++) begin
            c    = isqrt64(c << 30);
            t[i] = c[30:0];
        end
        return t;
    endfunction

    localparam exp_tab_t EXP_TAB = exp_table();

endpackage

FILE: hdl/baro_mul.sv
// shared signed multiplier with registered product
// depends on baro_pkg for widths
module baro_mul (
    input  logic                              aclk,
    input  logic signed [baro_pkg::MUL_W-1:0] a,
    input  logic signed [baro_pkg::MUL_W-1:0] b,
    output logic signed [baro_pkg::PROD_W-1:0] prod
);

    logic signed [baro_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= baro_pkg::PROD_W'(a) * baro_pkg::PROD_W'(b);
    end

    assign prod = prod_reg;

endmodule

FILE: hdl/barometric_altitude_with_zero_cal_unit.sv
// measure word: two log2 passes, one exp2 pass and a few steps, all on the one shared multiplier
// zero pressure or zero reference: straight to the output step
// calibration word: adds to the sum, and sets the reference to the mean when it closes an average
// one word in flight; next word taken the cycle after its result loads
// a finished result waits in the output register, which holds the sequencer while still full
// aresetn (synchronous, active low) restores reference 101325 and clears the average
module barometric_altitude_with_zero_cal_unit #(
    parameter int CAL_SAMPLES = 100
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_kind,
    input  logic [baro_pkg::P_W-1:0]            s_pressure,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [baro_pkg::ALT_W-1:0]   m_altitude_cm,
    output logic [baro_pkg::P_W-1:0]            m_reference_pressure,
    output logic                                m_calib_done,
    output logic                                m_saturated
);

`include "assert_macros.svh"

    localparam int CNT_W = $clog2(CAL_SAMPLES + 1);
    localparam logic [CNT_W-1:0] N_C = CNT_W'(CAL_SAMPLES);

    // mean by reciprocal multiply: shift and rounded-up reciprocal, exact for 24-bit sums
    localparam int     DIV_S      = baro_pkg::SUM_W + $clog2(CAL_SAMPLES);
    localparam longint DIV_M_FULL = ((longint'(1) << DIV_S) + longint'(CAL_SAMPLES - 1))
                                  / longint'(CAL_SAMPLES);
    localparam logic signed [baro_pkg::MUL_W-1:0] DIV_M = baro_pkg::MUL_W'(DIV_M_FULL);

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b0000_0000_0001,
        ST_DISP  = 12'b0000_0000_0010,
        ST_CAL   = 12'b0000_0000_0100,
        ST_DIV   = 12'b0000_0000_1000,
        ST_LOGP  = 12'b0000_0001_0000,
        ST_LOGR  = 12'b0000_0010_0000,
        ST_YMUL  = 12'b0000_0100_0000,
        ST_EXPO  = 12'b0000_1000_0000,
        ST_ALTLO = 12'b0001_0000_0000,
        ST_ALTHI = 12'b0010_0000_0000,
        ST_ALTS  = 12'b0100_0000_0000,
        ST_OUT   = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic [4:0] step_reg, step_next;

    logic                      kind_reg, kind_next;
    logic [baro_pkg::P_W-1:0]  p_reg, p_next;
    logic [baro_pkg::P_W-1:0]  ref_reg, ref_next;
    logic [baro_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0]          cal_count_reg, cal_count_next;

    logic [4:0]                top_reg, top_next;
    logic [baro_pkg::ITER-1:0] frac_reg, frac_next;
    logic [baro_pkg::LOG_W-1:0] lp_reg, lp_next;
    logic signed [baro_pkg::LDIF_W-1:0] l_reg, l_next;
    logic signed [2:0]         k_reg, k_next;
    logic [baro_pkg::ITER-1:0] f_reg, f_next;
    logic signed [29:0]        d_reg, d_next;
    logic [38:0]               acc_reg, acc_next;

    logic signed [baro_pkg::ALT_W-1:0] res_alt_reg, res_alt_next;
    logic                      res_sat_reg, res_sat_next;
    logic                      res_done_reg, res_done_next;

    logic                      m_valid_reg, m_valid_next;
    logic signed [baro_pkg::ALT_W-1:0] m_alt_reg, m_alt_next;
    logic [baro_pkg::P_W-1:0]  m_ref_reg, m_ref_next;
    logic                      m_done_reg, m_done_next;
    logic                      m_sat_reg, m_sat_next;

    logic signed [baro_pkg::MUL_W-1:0]  mul_a, mul_b;
    logic signed [baro_pkg::PROD_W-1:0] prod;

    baro_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // log2 front end: top set bit and normalized mantissa of the operand
    logic [baro_pkg::P_W-1:0] lx;
    logic [4:0]               ltop;
    logic [30:0]              linit;
    logic [31:0]              sq;
    logic [30:0]              mnorm;

    always_comb begin
        lx   = (state_reg == ST_LOGP) ? p_reg : ref_reg;
        ltop = '0;
        for (int b = 0; b < baro_pkg::P_W; b++) begin
            if (lx[b]) begin
                ltop = 5'(b);
            end
        end
        linit = 31'(lx) << (5'd30 - ltop);
        sq    = prod[61:30];
        mnorm = sq[31] ? sq[31:1] : sq[30:0];
    end

    // exp2 tail and final scaling
    logic [30:0]              er;
    logic [2:0]               kneg;
    logic [33:0]              rsh;
    logic [27:0]              ee;
    logic signed [55:0]       asum;
    logic signed [31:0]       alt32;
    logic [baro_pkg::SUM_W-1:0] sum_add;
    logic [CNT_W-1:0]         cnt_inc;

    always_comb begin
        er   = prod[60:30];
        kneg = 3'(-k_reg);
        rsh  = k_reg[2] ? (34'(er) >> kneg) : (34'(er) << k_reg);
        ee   = rsh[33:6];

        asum  = (56'(prod) <<< 15) + 56'(signed'({1'b0, acc_reg})) + 56'sd8388608;
        alt32 = asum[55:24];

        sum_add = sum_reg + baro_pkg::SUM_W'(p_reg);
        cnt_inc = cal_count_reg + CNT_W'(1);
    end

    always_comb begin
        state_next     = state_reg;
        step_next      = step_reg;
        kind_next      = kind_reg;
        p_next         = p_reg;
        ref_next       = ref_reg;
        sum_next       = sum_reg;
        cal_count_next = cal_count_reg;
        top_next       = top_reg;
        frac_next      = frac_reg;
        lp_next        = lp_reg;
        l_next         = l_reg;
        k_next         = k_reg;
        f_next         = f_reg;
        d_next         = d_reg;
        acc_next       = acc_reg;
        res_alt_next   = res_alt_reg;
        res_sat_next   = res_sat_reg;
        res_done_next  = res_done_reg;
        m_valid_next   = m_valid_reg;
        m_alt_next     = m_alt_reg;
        m_ref_next     = m_ref_reg;
        m_done_next    = m_done_reg;
        m_sat_next     = m_sat_reg;
        mul_a          = '0;
        mul_b          = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    kind_next  = s_kind;
                    p_next     = s_pressure;
                    state_next = ST_DISP;
                end
            end
            ST_DISP: begin
                res_alt_next  = '0;
                res_sat_next  = 1'b0;
                res_done_next = 1'b0;
                step_next     = '0;
                if (kind_reg) begin
                    state_next = ST_CAL;
                end else if (p_reg == '0) begin
                    res_alt_next = baro_pkg::ALT_MAX;
                    state_next   = ST_OUT;
                end else if (ref_reg == '0) begin
                    res_alt_next = baro_pkg::ALT_MIN;
                    res_sat_next = 1'b1;
                    state_next   = ST_OUT;
                end else begin
                    state_next = ST_LOGP;
                end
            end
            ST_CAL: begin
                sum_next       = sum_add;
                cal_count_next = cnt_inc;
                if (cnt_inc >= N_C) begin
                    mul_a      = baro_pkg::MUL_W'(sum_add);
                    mul_b      = DIV_M;
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_DIV: begin
                ref_next       = prod[DIV_S +: baro_pkg::P_W];
                sum_next       = '0;
                cal_count_next = '0;
                res_done_next  = 1'b1;
                state_next     = ST_OUT;
            end
            ST_LOGP, ST_LOGR: begin
                // each step squares the mantissa; overflow past 2.0 gives a fraction bit
                if (step_reg == '0) begin
                    top_next = ltop;
                    mul_a    = {1'b0, linit};
                    mul_b    = {1'b0, linit};
                end else begin
                    frac_next = {frac_reg[baro_pkg::ITER-2:0], sq[31]};
                    mul_a     = {1'b0, mnorm};
                    mul_b     = {1'b0, mnorm};
                end
                step_next = step_reg + 5'd1;
                if (step_reg == 5'(baro_pkg::ITER)) begin
                    step_next = '0;
                    if (state_reg == ST_LOGP) begin
                        lp_next    = {top_reg, frac_next};
                        state_next = ST_LOGR;
                    end else begin
                        l_next = baro_pkg::LDIF_W'(lp_reg)
                               - baro_pkg::LDIF_W'({top_reg, frac_next});
                        state_next = ST_YMUL;
                    end
                end
            end
            ST_YMUL: begin
                mul_a      = baro_pkg::MUL_W'(l_reg);
                mul_b      = {10'b0, baro_pkg::EXPO_Q24};
                step_next  = '0;
                state_next = ST_EXPO;
            end
            ST_EXPO: begin
                // product of 2^(2^-i) factors picked by the fraction bits
                if (step_reg == '0) begin
                    k_next = prod[50:48];
                    f_next = {prod[46:24], 1'b0};
                    mul_a  = {1'b0, baro_pkg::ONE_Q30};
                    mul_b  = {1'b0, prod[47] ? baro_pkg::EXP_TAB[0] : baro_pkg::ONE_Q30};
                end else begin
                    f_next = {f_reg[baro_pkg::ITER-2:0], 1'b0};
                    mul_a  = {1'b0, er};
                    mul_b  = {1'b0, f_reg[baro_pkg::ITER-1]
                                    ? baro_pkg::EXP_TAB[step_reg]
                                    : baro_pkg::ONE_Q30};
                end
                step_next = step_reg + 5'd1;
                if (step_reg == 5'(baro_pkg::ITER)) begin
                    mul_a      = '0;
                    mul_b      = '0;
                    d_next     = 30'sd16777216 - signed'(30'(ee));
                    state_next = ST_ALTLO;
                end
            end
            ST_ALTLO: begin
                mul_a      = {17'b0, d_reg[14:0]};
                mul_b      = {9'b0, baro_pkg::ALT_SCALE};
                state_next = ST_ALTHI;
            end
            ST_ALTHI: begin
                acc_next   = prod[38:0];
                mul_a      = {{17{d_reg[29]}}, d_reg[29:15]};
                mul_b      = {9'b0, baro_pkg::ALT_SCALE};
                state_next = ST_ALTS;
            end
            ST_ALTS: begin
                if (alt32 > 32'(baro_pkg::ALT_MAX)) begin
                    res_alt_next = baro_pkg::ALT_MAX;
                    res_sat_next = 1'b1;
                end else if (alt32 < 32'(baro_pkg::ALT_MIN)) begin
                    res_alt_next = baro_pkg::ALT_MIN;
                    res_sat_next = 1'b1;
                end else begin
                    res_alt_next = alt32[baro_pkg::ALT_W-1:0];
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_alt_next   = res_alt_reg;
                    m_ref_next   = ref_reg;
                    m_done_next  = res_done_reg;
                    m_sat_next   = res_sat_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            ref_reg       <= baro_pkg::REF_RESET;
            sum_reg       <= '0;
            cal_count_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            ref_reg       <= ref_next;
            sum_reg       <= sum_next;
            cal_count_reg <= cal_count_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg     <= kind_next;
        p_reg        <= p_next;
        top_reg      <= top_next;
        frac_reg     <= frac_next;
        lp_reg       <= lp_next;
        l_reg        <= l_next;
        k_reg        <= k_next;
        f_reg        <= f_next;
        d_reg        <= d_next;
        acc_reg      <= acc_next;
        res_alt_reg  <= res_alt_next;
        res_sat_reg  <= res_sat_next;
        res_done_reg <= res_done_next;
        m_alt_reg    <= m_alt_next;
        m_ref_reg    <= m_ref_next;
        m_done_reg   <= m_done_next;
        m_sat_reg    <= m_sat_next;
    end

    assign s_ready              = (state_reg == ST_IDLE);
    assign m_valid              = m_valid_reg;
    assign m_altitude_cm        = m_alt_reg;
    assign m_reference_pressure = m_ref_reg;
    assign m_calib_done         = m_done_reg;
    assign m_saturated          = m_sat_reg;

    `ASSERT_IMPLY(a_valid_from_out, aclk, aresetn, $rose(m_valid_reg), $past(state_reg == ST_OUT), "result word appeared outside the output step")
    `ASSERT_ALWAYS(a_count_range, aclk, aresetn, cal_count_reg <= N_C, "calibration count ran past its limit")
    `ASSERT_IMPLY(a_done_zero_alt, aclk, aresetn, m_valid_reg && m_calib_done, m_altitude_cm == '0 && !m_saturated, "calibration word carries altitude")
    `ASSERT_IMPLY(a_sat_bound, aclk, aresetn, m_valid_reg && m_saturated, m_altitude_cm == baro_pkg::ALT_MIN || m_altitude_cm == baro_pkg::ALT_MAX, "saturated word not at a bound")

endmodule
